// File: rtl/voxel_active_cell_finder_macros.svh
// Assertion macros used by the port-level checker (vacf_checker) of the voxel active cell finder.
// Depends on nothing; expects clk and arst_n in the scope where a macro is used.
`ifndef VOXEL_ACTIVE_CELL_FINDER_MACROS_SVH
`define VOXEL_ACTIVE_CELL_FINDER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define VACF_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vacf check failed");

// Next-cycle implication, disabled during reset.
`define VACF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vacf check failed");

`endif

// File: rtl/vacf_pkg.sv
// Package of the voxel active cell finder: sizes, codes, payload and control structs.
// Depends on nothing; used by every RTL module of the block except vacf_ram.
package vacf_pkg;

	localparam int SIDE        = 32;
	localparam int LOD_COUNT   = 5;
	localparam int COORD_W     = 5;
	localparam int DENS_W      = 8;
	localparam int LEVEL_W     = 3;
	localparam int INDEX_W     = 15;
	localparam int VOLUME      = SIDE * SIDE * SIDE;
	localparam int ADDR_W      = $clog2(VOLUME);
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;

	localparam logic [DENS_W-1:0] SET_LIMIT  = 8'd127;
	localparam logic [DENS_W-1:0] FULL_VALUE = 8'd255;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_PROBE = 1'b1;

	localparam logic [CFG_INDEX_W-1:0] CFG_LOD_ENABLED = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_LOD = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_FILL_FULL   = 2'd2;

	typedef struct packed {
		logic               cmd;
		logic [COORD_W-1:0] vx;
		logic [COORD_W-1:0] vy;
		logic [COORD_W-1:0] vz;
		logic [DENS_W-1:0]  density;
	} item_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [INDEX_W-1:0] cell_index;
		logic               last;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic take_item;
		logic fill_start;
		logic fill_step;
		logic set_ready;
		logic do_write;
		logic level_init;
		logic level_next;
		logic corner_clear;
		logic corner_read;
		logic keep_result;
		logic clear_pending;
		logic emit;
		logic emit_last;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic cmd_write;
		logic store_ready;
		logic in_grid;
		logic fill_last;
		logic level_done;
		logic level_ok;
		logic corner_last;
		logic active;
		logic pending;
		logic out_free;
	} dp_status_t;

	// linear index x*SIDE*SIDE + y*SIDE + z
	function automatic logic [31:0] lin(input logic [COORD_W-1:0] x,
		input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z);
		return 32'(x) * 32'(SIDE * SIDE) + 32'(y) * 32'(SIDE) + 32'(z);
	endfunction

endpackage

// File: rtl/voxel_active_cell_finder.sv
// Top level of the voxel active cell finder: controller plus datapath.
// Depends on vacf_pkg, vacf_ctrl, vacf_datapath (which holds the vacf_ram store).
//
//  channel   signals                                  direction
//  item      item_valid / item_ready / item (item_t)  in
//  result    result_valid / result_ready / result     out
//  cfg       cfg_valid / cfg_ready / cfg_index, data  in  (always ready)
//
// Write: states IDLE, DISPATCH, WRITE; the first write after reset first sweeps the fill value
// over all SIDE^3 = 32768 store entries, one per cycle. Probe: each level in range passes LEVEL
// and is skipped, or its 8 corners are scanned through the one store read port (READ, TAIL,
// EVAL), for up to five levels; a probe on an unused store goes back to idle without a scan.
// One active cell waits in a pending register (to mark last), one in the output register;
// a stalled result stalls the scan. Reset clears control state, not the store contents.
module voxel_active_cell_finder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  vacf_pkg::item_t                 item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output vacf_pkg::result_t               result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [vacf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [vacf_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import vacf_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// config registers take every transaction
	assign cfg_ready = 1'b1;

	vacf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.status    (status),
		.cmd       (cmd)
	);

	vacf_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.item        (item),
		.cmd         (cmd),
		.status      (status),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);
endmodule

// File: rtl/vacf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module vacf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// File: rtl/vacf_datapath.sv
// Datapath: config registers, item register, density store, level and corner
// counters, corner classification, pending result and output register. Uses vacf_pkg, vacf_ram.
module vacf_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [vacf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [vacf_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  vacf_pkg::item_t                 item,
	input  vacf_pkg::ctrl_cmd_t             cmd,
	output vacf_pkg::dp_status_t            status,
	output logic                            result_valid,
	input  logic                            result_ready,
	output vacf_pkg::result_t               result
);
	import vacf_pkg::*;

	logic               lod_enabled_q;
	logic [LEVEL_W-1:0] initial_lod_q;
	logic               fill_full_q;
	item_t              item_q;
	logic               store_ready_q;
	logic [ADDR_W-1:0]  fill_q;
	logic [LEVEL_W-1:0] l_q;
	logic [2:0]         corner_q;
	logic               rd_valid_s1;
	logic               any_set_q;
	logic               any_clear_q;
	logic               pend_valid_q;
	logic [LEVEL_W-1:0] pend_level_q;
	logic [INDEX_W-1:0] pend_index_q;
	logic               out_valid_q;
	result_t            out_q;

	logic [7:0]         step;
	logic [7:0]         step_mask;
	logic [7:0]         xe, ye, ze;
	logic [3:0]         level_hi;
	logic               level_done;
	logic               guard;
	logic [COORD_W-1:0] sv;
	logic [COORD_W-1:0] lx, ly, lz;
	logic [COORD_W-1:0] cx, cy, cz;
	logic [31:0]        w_lin, r_lin, low_lin;
	logic               in_grid;
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [DENS_W-1:0]  ram_wdata;
	logic [DENS_W-1:0]  ram_rdata;
	logic               corner_set;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lod_enabled_q <= 1'b1;
			initial_lod_q <= '0;
			fill_full_q   <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_LOD_ENABLED: lod_enabled_q <= cfg_data[0];
				CFG_INITIAL_LOD: initial_lod_q <= cfg_data[LEVEL_W-1:0];
				CFG_FILL_FULL:   fill_full_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			item_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_ready_q <= 1'b0;
			fill_q        <= '0;
			l_q           <= '0;
			corner_q      <= '0;
			rd_valid_s1   <= 1'b0;
			any_set_q     <= 1'b0;
			any_clear_q   <= 1'b0;
			pend_valid_q  <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.set_ready) begin
				store_ready_q <= 1'b1;
			end
			if (cmd.fill_start) begin
				fill_q <= '0;
			end else if (cmd.fill_step) begin
				fill_q <= fill_q + 1'b1;
			end
			if (cmd.level_init) begin
				l_q <= lod_enabled_q ? initial_lod_q : '0;
			end else if (cmd.level_next) begin
				l_q <= l_q + 1'b1;
			end
			if (cmd.corner_clear) begin
				corner_q <= '0;
			end else if (cmd.corner_read) begin
				corner_q <= corner_q + 1'b1;
			end
			rd_valid_s1 <= cmd.corner_read;
			if (cmd.corner_clear) begin
				any_set_q   <= 1'b0;
				any_clear_q <= 1'b0;
			end else if (rd_valid_s1) begin
				any_set_q   <= any_set_q | corner_set;
				any_clear_q <= any_clear_q | !corner_set;
			end
			if (cmd.clear_pending) begin
				pend_valid_q <= 1'b0;
			end else if (cmd.keep_result) begin
				pend_valid_q <= 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.keep_result) begin
			pend_level_q <= l_q;
			pend_index_q <= low_lin[INDEX_W-1:0];
		end
		if (cmd.emit) begin
			out_q.level      <= pend_level_q;
			out_q.cell_index <= pend_index_q;
			out_q.last       <= cmd.emit_last;
		end
	end

	// level guard
	assign step       = 8'd1 << l_q;
	assign step_mask  = step - 8'd1;
	assign xe         = 8'(item_q.vx);
	assign ye         = 8'(item_q.vy);
	assign ze         = 8'(item_q.vz);
	assign level_hi   = lod_enabled_q ? 4'(LOD_COUNT) : 4'd1;
	assign level_done = {1'b0, l_q} >= level_hi;
	assign guard      = (xe >= step) && (ye >= step) && (ze >= step)
		&& ((xe & step_mask) == 8'd0) && ((ye & step_mask) == 8'd0)
		&& ((ze & step_mask) == 8'd0);

	// corners; guard keeps step below 2^COORD_W when used
	assign sv = step[COORD_W-1:0];
	assign lx = item_q.vx - sv;
	assign ly = item_q.vy - sv;
	assign lz = item_q.vz - sv;
	assign cx = corner_q[0] ? lx : item_q.vx;
	assign cy = corner_q[1] ? ly : item_q.vy;
	assign cz = corner_q[2] ? lz : item_q.vz;

	assign w_lin   = lin(item_q.vx, item_q.vy, item_q.vz);
	assign r_lin   = lin(cx, cy, cz);
	assign low_lin = lin(lx, ly, lz);
	assign in_grid = (int'(item_q.vx) < SIDE) && (int'(item_q.vy) < SIDE)
		&& (int'(item_q.vz) < SIDE);

	assign ram_we    = cmd.fill_step | (cmd.do_write & in_grid);
	assign ram_waddr = cmd.fill_step ? fill_q : w_lin[ADDR_W-1:0];
	assign ram_wdata = cmd.fill_step ? (fill_full_q ? FULL_VALUE : '0) : item_q.density;

	vacf_ram #(
		.WIDTH(DENS_W),
		.DEPTH(VOLUME)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.corner_read),
		.raddr(r_lin[ADDR_W-1:0]),
		.rdata(ram_rdata)
	);

	assign corner_set = ram_rdata <= SET_LIMIT;

	always_comb begin
		status.cmd_write   = item_q.cmd == CMD_WRITE;
		status.store_ready = store_ready_q;
		status.in_grid     = in_grid;
		status.fill_last   = fill_q == ADDR_W'(VOLUME - 1);
		status.level_done  = level_done;
		status.level_ok    = !level_done && guard;
		status.corner_last = corner_q == 3'd7;
		status.active      = any_set_q & any_clear_q;
		status.pending     = pend_valid_q;
		status.out_free    = !out_valid_q || result_ready;
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;
endmodule

// File: rtl/vacf_ctrl.sv
// Controller state machine: sequences fill, write and the per-level corner scan.
// Depends on vacf_pkg; drives vacf_datapath through ctrl_cmd_t.
module vacf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  vacf_pkg::dp_status_t status,
	output vacf_pkg::ctrl_cmd_t  cmd
);
	import vacf_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DISPATCH = 4'd1;
	localparam logic [3:0] S_FILL     = 4'd2;
	localparam logic [3:0] S_WRITE    = 4'd3;
	localparam logic [3:0] S_LEVEL    = 4'd4;
	localparam logic [3:0] S_READ     = 4'd5;
	localparam logic [3:0] S_TAIL     = 4'd6;
	localparam logic [3:0] S_EVAL     = 4'd7;
	localparam logic [3:0] S_FLUSH    = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.take_item = 1'b1;
					state_d       = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (status.cmd_write) begin
					if (status.store_ready) begin
						state_d = S_WRITE;
					end else begin
						cmd.fill_start = 1'b1;
						state_d        = S_FILL;
					end
				end else if (!status.store_ready || !status.in_grid) begin
					state_d = S_IDLE;
				end else begin
					cmd.level_init = 1'b1;
					state_d        = S_LEVEL;
				end
			end
			S_FILL: begin
				cmd.fill_step = 1'b1;
				if (status.fill_last) begin
					cmd.set_ready = 1'b1;
					state_d       = S_WRITE;
				end
			end
			S_WRITE: begin
				cmd.do_write = 1'b1;
				state_d      = S_IDLE;
			end
			S_LEVEL: begin
				if (status.level_done) begin
					state_d = S_FLUSH;
				end else if (status.level_ok) begin
					cmd.corner_clear = 1'b1;
					state_d          = S_READ;
				end else begin
					cmd.level_next = 1'b1;
				end
			end
			S_READ: begin
				cmd.corner_read = 1'b1;
				if (status.corner_last) begin
					state_d = S_TAIL;
				end
			end
			S_TAIL: begin
				state_d = S_EVAL;
			end
			S_EVAL: begin
				if (!status.active) begin
					cmd.level_next = 1'b1;
					state_d        = S_LEVEL;
				end else if (!status.pending) begin
					cmd.keep_result = 1'b1;
					cmd.level_next  = 1'b1;
					state_d         = S_LEVEL;
				end else if (status.out_free) begin
					cmd.emit        = 1'b1;
					cmd.keep_result = 1'b1;
					cmd.level_next  = 1'b1;
					state_d         = S_LEVEL;
				end
			end
			S_FLUSH: begin
				if (!status.pending) begin
					state_d = S_IDLE;
				end else if (status.out_free) begin
					cmd.emit          = 1'b1;
					cmd.emit_last     = 1'b1;
					cmd.clear_pending = 1'b1;
					state_d           = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule

// File: rtl/vacf_checker.sv
// Port-level checker for voxel_active_cell_finder, bound to the top level.
// Depends on vacf_pkg and voxel_active_cell_finder_macros.svh.
`include "voxel_active_cell_finder_macros.svh"

module vacf_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input logic              result_valid,
	input logic              result_ready,
	input vacf_pkg::result_t result
);
	import vacf_pkg::*;

	// stalled result holds
	`VACF_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))

	// one item at a time
	`VACF_ASSERT_NEXT(a_one_item, item_valid && item_ready, !item_ready)

	// a non-final result means the probe is still running
	`VACF_ASSERT_SAME(a_probe_busy, result_valid && !result.last, !item_ready)
endmodule

bind voxel_active_cell_finder vacf_checker u_vacf_checker (.*);

// File: tb/vacf_cell_checker.sv
// Scoreboard of the voxel active cell finder: mirrors the density store and the
// registers, predicts the active cells of each probe and checks every result transaction.
// Depends on vacf_pkg only.
module vacf_cell_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	input  logic                             item_ready,
	input  vacf_pkg::item_t                  item,
	input  logic                             result_valid,
	input  logic                             result_ready,
	input  vacf_pkg::result_t                result,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [vacf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [vacf_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int unsigned                      fail_count,
	output int unsigned                      awaited
);
	timeunit 1ns;
	timeprecision 1ps;

	import vacf_pkg::*;

	localparam int unsigned REPORT_LIMIT = 10;

	logic [DENS_W-1:0] density_mirror [VOLUME];
	bit                mirror_live;
	bit                lod_on;
	logic [2:0]        base_lod;
	bit                fill_ones;
	result_t           cells_due [$];

	// SIDE is 32, so the linear index is just the three coordinates side by side
	function automatic logic [INDEX_W-1:0] voxel_addr(input logic [COORD_W-1:0] x,
		input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z);
		return {x, y, z};
	endfunction

	function automatic bit corner_is_set(input logic [COORD_W-1:0] x,
		input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z);
		return density_mirror[voxel_addr(x, y, z)] <= SET_LIMIT;
	endfunction

	function automatic void note_failure(input string what);
		if (fail_count < REPORT_LIMIT)
			$display("%0t ns: %s", $realtime, what);
		fail_count++;
	endfunction

	function automatic void store_density(input item_t it);
		if (!mirror_live) begin
			foreach (density_mirror[i])
				density_mirror[i] = fill_ones ? FULL_VALUE : DENS_W'(0);
			mirror_live = 1'b1;
		end
		density_mirror[voxel_addr(it.vx, it.vy, it.vz)] = it.density;
	endfunction

	function automatic void classify_probe(input item_t it);
		int                 lo;
		int                 hi;
		int                 step;
		int                 set_count;
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
		logic [COORD_W-1:0] cz;
		result_t            hit;
		result_t            found [$];
		if (!mirror_live)
			return;
		lo = lod_on ? int'(base_lod) : 0;
		hi = lod_on ? LOD_COUNT : 1;
		for (int lvl = lo; lvl < hi; lvl++) begin
			step = 1 << lvl;
			if (it.vx < step || it.vy < step || it.vz < step)
				continue;
			if ((it.vx % step) != 0 || (it.vy % step) != 0 || (it.vz % step) != 0)
				continue;
			set_count = 0;
			for (int k = 0; k < 8; k++) begin
				cx = k[0] ? COORD_W'(it.vx - step) : it.vx;
				cy = k[1] ? COORD_W'(it.vy - step) : it.vy;
				cz = k[2] ? COORD_W'(it.vz - step) : it.vz;
				if (corner_is_set(cx, cy, cz))
					set_count++;
			end
			if (set_count == 0 || set_count == 8)
				continue;
			hit.level      = LEVEL_W'(lvl);
			hit.cell_index = voxel_addr(COORD_W'(it.vx - step), COORD_W'(it.vy - step),
				COORD_W'(it.vz - step));
			hit.last       = 1'b0;
			found.push_back(hit);
		end
		if (found.size() != 0)
			found[found.size() - 1].last = 1'b1;
		foreach (found[i])
			cells_due.push_back(found[i]);
	endfunction

	function automatic void check_cell(input result_t got);
		result_t want;
		if (cells_due.size() == 0) begin
			note_failure($sformatf("unexpected result: level %0d index %0d last %0b",
				got.level, got.cell_index, got.last));
			return;
		end
		want = cells_due.pop_front();
		if (got.level !== want.level || got.cell_index !== want.cell_index ||
			got.last !== want.last)
			note_failure($sformatf({"result differs: level exp %0d got %0d, ",
				"index exp %0d got %0d, last exp %0b got %0b"},
				want.level, got.level, want.cell_index, got.cell_index, want.last, got.last));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_due.delete();
			fail_count  = 0;
			mirror_live = 1'b0;
			lod_on      = 1'b1;
			base_lod    = '0;
			fill_ones   = 1'b0;
		end else begin
			// results first: a result can never belong to a probe taken on the same edge
			if (result_valid && result_ready)
				check_cell(result);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_LOD_ENABLED: lod_on    = cfg_data[0];
					CFG_INITIAL_LOD: base_lod  = cfg_data[2:0];
					CFG_FILL_FULL:   fill_ones = cfg_data[0];
					default: ;
				endcase
			end
			if (item_valid && item_ready) begin
				if (item.cmd == CMD_WRITE)
					store_density(item);
				else
					classify_probe(item);
			end
		end
		awaited = cells_due.size();
	end

endmodule

// File: tb/voxel_active_cell_finder_test.sv
// Top of the voxel active cell finder testbench: clock, reset, stimulus and verdict.
// Depends on vacf_pkg, the block voxel_active_cell_finder and the scoreboard vacf_cell_checker.
module voxel_active_cell_finder_test;
	timeunit 1ns;
	timeprecision 1ps;

	import vacf_pkg::*;

	// bound for the slowest legal run (fill sweep, long gaps and stalls); keep margin
	localparam int unsigned LIMIT_CYCLES = 1_000_000;
	// covers the scan of a full five-level probe with no result
	localparam int unsigned DRAIN_CYCLES = 100;
	// long receiver hold-off that backs the block up into its input
	localparam int unsigned HOLD_CYCLES  = 600;

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   item_valid   = 1'b0;
	logic                   item_ready;
	item_t                  item_bus     = '0;
	logic                   result_valid;
	logic                   result_ready = 1'b0;
	result_t                result_bus;
	logic                   cfg_valid    = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index    = '0;
	logic [CFG_DATA_W-1:0]  cfg_data     = '0;
	int unsigned            fail_count;
	int unsigned            awaited;

	// idling knobs, in percent per cycle
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	bit          hold_req       = 1'b0;
	int unsigned items_sent     = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	voxel_active_cell_finder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item_bus),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result_bus),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	vacf_cell_checker i_cell_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item_bus),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result_bus),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.awaited      (awaited)
	);

	// Result sink. Random back-pressure per the current phase; a hold request
	// turns ready off once for a long fixed stretch, counted here.
	initial begin : result_sink
		int unsigned hold_left;
		bit          hold_taken;
		hold_left  = 0;
		hold_taken = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin : watchdog
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("voxel_active_cell_finder: mismatch");
		$finish;
	end

	// All driving tasks start and end at a falling edge.
	// Valid stays high from one transaction to the next unless the sender idles,
	// so valid is never dropped and raised in the same step.
	task automatic send_item(input item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item_bus   <= it;
		do @(posedge clk); while (!item_ready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_write(input int x, input int y, input int z,
		input logic [DENS_W-1:0] dens);
		item_t it;
		it.cmd     = CMD_WRITE;
		it.vx      = COORD_W'(x);
		it.vy      = COORD_W'(y);
		it.vz      = COORD_W'(z);
		it.density = dens;
		send_item(it);
	endtask

	task automatic send_probe(input int x, input int y, input int z);
		item_t it;
		it.cmd     = CMD_PROBE;
		it.vx      = COORD_W'(x);
		it.vy      = COORD_W'(y);
		it.vz      = COORD_W'(z);
		it.density = DENS_W'($urandom);
		send_item(it);
	endtask

	// cfg_valid goes low after the transaction is taken and the task returns only after
	// that, so back-to-back writes never collide
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Block goes quiet: every predicted cell delivered, then room for a probe
	// that finds nothing to finish its scan.
	task automatic settle();
		item_valid <= 1'b0;
		while (awaited != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_idling(input int unsigned send_pct, input int unsigned stall_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = stall_pct;
	endtask

	// density on a chosen side of the set/clear threshold, often at its edges
	function automatic logic [DENS_W-1:0] pick_density(input bit want_set);
		case ($urandom_range(3))
			0:       return want_set ? SET_LIMIT : DENS_W'(SET_LIMIT + 1);
			1:       return want_set ? DENS_W'(0) : FULL_VALUE;
			default: return want_set ? DENS_W'($urandom_range(SET_LIMIT)) :
				DENS_W'($urandom_range(FULL_VALUE, SET_LIMIT + 1));
		endcase
	endfunction

	// One well-formed sequence: pick a high corner aligned to some level, write
	// corners of the cells at that level and below (some levels skipped), then probe it. Modes give
	// all-set, all-clear or mixed cells; only mixed mode leaves single corners of a written level unwritten.
	task automatic cell_burst();
		int unsigned top_lvl;
		int unsigned span;
		int unsigned mode;
		int          step;
		int          hx;
		int          hy;
		int          hz;
		bit          want_set;
		top_lvl = $urandom_range(LOD_COUNT - 1);
		span    = (SIDE - 1) >> top_lvl;
		hx      = $urandom_range(span, 1) << top_lvl;
		hy      = $urandom_range(span, 1) << top_lvl;
		hz      = $urandom_range(span, 1) << top_lvl;
		mode    = $urandom_range(3);
		for (int lvl = 0; lvl <= top_lvl; lvl++) begin
			step = 1 << lvl;
			if ($urandom_range(2) == 0)
				continue;
			for (int k = 0; k < 8; k++) begin
				if (mode >= 2 && $urandom_range(99) < 60)
					continue;
				want_set = (mode == 0) || (mode >= 2 && $urandom_range(1) == 1);
				send_write(k[0] ? hx - step : hx, k[1] ? hy - step : hy,
					k[2] ? hz - step : hz, pick_density(want_set));
			end
		end
		send_probe(hx, hy, hz);
	endtask

	// Random part: mostly cell sequences, the rest raw items with every field random.
	task automatic random_phase(input int unsigned count);
		int unsigned stop_at;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			if ($urandom_range(99) < 20)
				send_item(item_t'(24'($urandom)));
			else
				cell_burst();
		end
	endtask

	initial begin : stimulus
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// --- directed part, no idling ---
		// probe before any write: store unused, nothing comes back
		send_probe(16, 16, 16);
		settle();
		// first write fills the store with 255 before storing its own byte
		write_reg(CFG_FILL_FULL, CFG_DATA_W'(1));
		send_write(0, 0, 0, DENS_W'(0));
		send_probe(1, 1, 1);
		// threshold edges at the far corner of the grid
		send_write(31, 31, 31, SET_LIMIT);
		send_write(30, 31, 31, DENS_W'(SET_LIMIT + 1));
		send_probe(31, 31, 31);
		// one set low corner per level around (16,16,16): five results, one per level
		for (int lvl = 0; lvl < LOD_COUNT; lvl++)
			send_write(16 - (1 << lvl), 16 - (1 << lvl), 16 - (1 << lvl), DENS_W'(0));
		send_probe(16, 16, 16);
		// all level-0 corners clear; the level-1 cell still holds the set corner (8,8,8)
		send_write(10, 10, 10, FULL_VALUE);
		send_probe(10, 10, 10);
		settle();
		// LOD off: level zero only, and the lower-bound guard on a zero coordinate
		write_reg(CFG_LOD_ENABLED, CFG_DATA_W'(0));
		send_probe(16, 16, 16);
		send_probe(0, 5, 5);
		settle();
		write_reg(CFG_LOD_ENABLED, CFG_DATA_W'(1));
		write_reg(CFG_INITIAL_LOD, CFG_DATA_W'(LOD_COUNT - 1));
		send_probe(16, 16, 16);
		settle();
		// initial level at and past the level count: nothing checked
		write_reg(CFG_INITIAL_LOD, CFG_DATA_W'(LOD_COUNT));
		send_probe(16, 16, 16);
		settle();
		write_reg(CFG_INITIAL_LOD, CFG_DATA_W'(7));
		send_probe(16, 16, 16);
		settle();
		write_reg(CFG_INITIAL_LOD, CFG_DATA_W'(2));
		send_probe(16, 16, 16);

		// --- random phases, each under its own register setting ---
		settle();
		write_reg(CFG_INITIAL_LOD, CFG_DATA_W'(0));
		set_idling(0, 0);
		random_phase(70);

		settle();
		write_reg(CFG_INITIAL_LOD, CFG_DATA_W'(1));
		set_idling(86, 0);
		random_phase(55);

		settle();
		// fill value no longer matters once the store is in use
		write_reg(CFG_LOD_ENABLED, CFG_DATA_W'(0));
		write_reg(CFG_FILL_FULL, CFG_DATA_W'(0));
		set_idling(0, 86);
		random_phase(55);

		settle();
		write_reg(CFG_LOD_ENABLED, CFG_DATA_W'(1));
		write_reg(CFG_INITIAL_LOD, CFG_DATA_W'(3));
		set_idling(35, 35);
		random_phase(50);

		// receiver holds off while the sender keeps offering: the output
		// register fills and the scan backs up into the item channel
		settle();
		write_reg(CFG_INITIAL_LOD, CFG_DATA_W'(0));
		set_idling(0, 0);
		hold_req = 1'b1;
		random_phase(50);

		settle();
		write_reg(CFG_INITIAL_LOD, CFG_DATA_W'(LOD_COUNT - 1));
		set_idling(35, 35);
		random_phase(40);

		settle();
		if (fail_count == 0)
			$display("voxel_active_cell_finder: match");
		else
			$display("voxel_active_cell_finder: mismatch");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/vacf_pkg.sv
rtl/vacf_ram.sv
rtl/vacf_datapath.sv
rtl/vacf_ctrl.sv
rtl/voxel_active_cell_finder.sv
rtl/vacf_checker.sv
tb/vacf_cell_checker.sv
tb/voxel_active_cell_finder_test.sv
